// ===== rtl/core/ffpa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared constants, codes and state type of the first-fit partition allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

   localparam int TABLE_ENTRIES_DEF  = 16;
   localparam int MEM_UNITS_DEF      = 1024;
   localparam int RESERVED_UNITS_DEF = 100;

   localparam logic CMD_ALLOC   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_NOFIT = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   typedef enum logic [11:0] {
      S_INIT  = 12'b0000_0000_0001,
      S_IDLE  = 12'b0000_0000_0010,
      S_A_RD  = 12'b0000_0000_0100,
      S_A_CHK = 12'b0000_0000_1000,
      S_R_RD  = 12'b0000_0001_0000,
      S_R_CHK = 12'b0000_0010_0000,
      S_R_DEC = 12'b0000_0100_0000,
      S_D_RD  = 12'b0000_1000_0000,
      S_D_WR  = 12'b0001_0000_0000,
      S_I_RD  = 12'b0010_0000_0000,
      S_I_WR  = 12'b0100_0000_0000,
      S_DONE  = 12'b1000_0000_0000
   } state_type;

endpackage

// ===== rtl/core/first_fit_partition_allocator.sv =====
// Flow, from accepting a word to rsp_valid: the scan reads the table entries in turn;
//   a release adds a decision step, and a further read step when its scan runs past the
//   last entry; removing or inserting an entry moves each entry behind it one place,
//   with a read and a write per entry moved and a final read step.
// Throughput: one word at a time; req_stall stays high until its response is loaded.
// Reset: synchronous; S_INIT, the state after reset, writes the initial free entry when RESERVED_UNITS < MEM_UNITS.
// ----------------------------------------------------------------------------
// first_fit_partition_allocator
// Free-partition table in memory with first-fit allocate and coalescing release.
// ----------------------------------------------------------------------------
module first_fit_partition_allocator
   import ffpa_pkg::*;
#(
   parameter int TABLE_ENTRIES  = TABLE_ENTRIES_DEF,
   parameter int MEM_UNITS      = MEM_UNITS_DEF,
   parameter int RESERVED_UNITS = RESERVED_UNITS_DEF,
   localparam int START_W = $clog2(MEM_UNITS),
   localparam int SIZE_W  = $clog2(MEM_UNITS + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_command,
   input  logic [SIZE_W-1:0]  req_request_size,
   input  logic [START_W-1:0] req_block_start,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [START_W-1:0] rsp_granted_start
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int SUM_W = SIZE_W + 1;

   logic [START_W-1:0] mem_start [TABLE_ENTRIES];
   logic [SIZE_W-1:0]  mem_size  [TABLE_ENTRIES];
   logic [START_W-1:0] rd_start_ff;
   logic [SIZE_W-1:0]  rd_size_ff;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [START_W-1:0] wr_start;
   logic [SIZE_W-1:0]  wr_size;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   pos_ff, pos_in;
   logic [SIZE_W-1:0]  len_ff, len_in;
   logic [START_W-1:0] s_ff, s_in;
   logic [START_W-1:0] prev_start_ff, prev_start_in;
   logic [SIZE_W-1:0]  prev_size_ff, prev_size_in;
   logic [START_W-1:0] next_start_ff, next_start_in;
   logic [SIZE_W-1:0]  next_size_ff, next_size_in;
   logic [1:0]         stat_ff, stat_in;
   logic [START_W-1:0] gnt_ff, gnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [START_W-1:0] rsp_start_ff, rsp_start_in;

   logic [SUM_W-1:0]   req_end;
   logic [SUM_W-1:0]   rel_end;
   logic               join_prev, join_next;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_start[wr_addr] <= wr_start;
         mem_size[wr_addr]  <= wr_size;
      end
      rd_start_ff <= mem_start[rd_addr];
      rd_size_ff  <= mem_size[rd_addr];
   end

   assign req_end   = SUM_W'(req_block_start) + SUM_W'(req_request_size);
   assign rel_end   = SUM_W'(s_ff) + SUM_W'(len_ff);
   assign join_prev = (pos_ff != '0) &&
                      (SUM_W'(prev_start_ff) + SUM_W'(prev_size_ff) == SUM_W'(s_ff));
   assign join_next = (pos_ff < count_ff) && (rel_end == SUM_W'(next_start_ff));

   assign rd_addr = (state_ff == S_I_RD) ? IDX_W'(idx_ff - 1'b1) : idx_ff[IDX_W-1:0];

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      len_in        = len_ff;
      s_in          = s_ff;
      prev_start_in = prev_start_ff;
      prev_size_in  = prev_size_ff;
      next_start_in = next_start_ff;
      next_size_in  = next_size_ff;
      stat_in       = stat_ff;
      gnt_in        = gnt_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff[IDX_W-1:0];
      wr_start      = rd_start_ff;
      wr_size       = rd_size_ff;

      unique case (state_ff)
         S_INIT: begin
            if (RESERVED_UNITS < MEM_UNITS) begin
               wr_en    = 1'b1;
               wr_addr  = '0;
               wr_start = START_W'(RESERVED_UNITS);
               wr_size  = SIZE_W'(MEM_UNITS - RESERVED_UNITS);
               count_in = CNT_W'(1);
            end else begin
               count_in = '0;
            end
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               len_in  = req_request_size;
               s_in    = req_block_start;
               idx_in  = '0;
               stat_in = STAT_OK;
               gnt_in  = '0;
               if (req_command == CMD_ALLOC) begin
                  if (req_request_size == '0 || count_ff == '0) begin
                     stat_in  = STAT_NOFIT;
                     state_in = S_DONE;
                  end else begin
                     state_in = S_A_RD;
                  end
               end else if (req_request_size == '0 || req_end > SUM_W'(MEM_UNITS)) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_R_RD;
               end
            end
         end
         S_A_RD: state_in = S_A_CHK;
         S_A_CHK: begin
            if (rd_size_ff >= len_ff) begin
               gnt_in = rd_start_ff;
               if (rd_size_ff == len_ff) begin
                  // entry used up: close the gap behind it
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_D_RD;
               end else begin
                  wr_en    = 1'b1;
                  wr_start = START_W'(SUM_W'(rd_start_ff) + SUM_W'(len_ff));
                  wr_size  = rd_size_ff - len_ff;
                  state_in = S_DONE;
               end
            end else if (idx_ff + 1'b1 >= count_ff) begin
               stat_in  = STAT_NOFIT;
               state_in = S_DONE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_A_RD;
            end
         end
         S_R_RD: begin
            if (idx_ff >= count_ff) begin
               pos_in   = idx_ff;
               state_in = S_R_DEC;
            end else begin
               state_in = S_R_CHK;
            end
         end
         S_R_CHK: begin
            if (rd_start_ff <= s_ff) begin
               prev_start_in = rd_start_ff;
               prev_size_in  = rd_size_ff;
               idx_in        = idx_ff + 1'b1;
               state_in      = S_R_RD;
            end else begin
               pos_in        = idx_ff;
               next_start_in = rd_start_ff;
               next_size_in  = rd_size_ff;
               state_in      = S_R_DEC;
            end
         end
         S_R_DEC: begin
            priority if (join_prev && join_next) begin
               wr_en    = 1'b1;
               wr_addr  = IDX_W'(pos_ff - 1'b1);
               wr_start = prev_start_ff;
               wr_size  = SIZE_W'(SUM_W'(prev_size_ff) + SUM_W'(len_ff)
                                  + SUM_W'(next_size_ff));
               idx_in   = pos_ff + 1'b1;
               state_in = S_D_RD;
            end else if (join_prev) begin
               wr_en    = 1'b1;
               wr_addr  = IDX_W'(pos_ff - 1'b1);
               wr_start = prev_start_ff;
               wr_size  = SIZE_W'(SUM_W'(prev_size_ff) + SUM_W'(len_ff));
               state_in = S_DONE;
            end else if (join_next) begin
               wr_en    = 1'b1;
               wr_addr  = pos_ff[IDX_W-1:0];
               wr_start = s_ff;
               wr_size  = SIZE_W'(SUM_W'(next_size_ff) + SUM_W'(len_ff));
               state_in = S_DONE;
            end else if (count_ff >= CNT_W'(TABLE_ENTRIES)) begin
               stat_in  = STAT_FULL;
               state_in = S_DONE;
            end else begin
               idx_in   = count_ff;
               state_in = S_I_RD;
            end
         end
         S_D_RD: begin
            if (idx_ff >= count_ff) begin
               count_in = count_ff - 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_D_WR;
            end
         end
         S_D_WR: begin
            // move the entry one place down
            wr_en    = 1'b1;
            wr_addr  = IDX_W'(idx_ff - 1'b1);
            idx_in   = idx_ff + 1'b1;
            state_in = S_D_RD;
         end
         S_I_RD: begin
            if (idx_ff == pos_ff) begin
               wr_en    = 1'b1;
               wr_addr  = pos_ff[IDX_W-1:0];
               wr_start = s_ff;
               wr_size  = len_ff;
               count_in = count_ff + 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_I_WR;
            end
         end
         S_I_WR: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff[IDX_W-1:0];
            idx_in   = idx_ff - 1'b1;
            state_in = S_I_RD;
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = stat_ff;
               rsp_start_in  = gnt_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      len_ff        <= len_in;
      s_ff          <= s_in;
      prev_start_ff <= prev_start_in;
      prev_size_ff  <= prev_size_in;
      next_start_ff <= next_start_in;
      next_size_ff  <= next_size_in;
      stat_ff       <= stat_in;
      gnt_ff        <= gnt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_start = rsp_start_ff;

endmodule
